// ----- rtl/core/bpa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and codes for the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_RESIDENT  = 3'd1,
        ST_FULL      = 3'd2,
        ST_NO_RUN    = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_NEXT  = 2'd1,
        FIT_BEST  = 2'd2,
        FIT_WORST = 2'd3
    } t_fit;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_UNLOAD = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_SCAN_LAST,
        S_PAGES,
        S_PAGE_FIN,
        S_MARK,
        S_FREE_RD,
        S_FREE,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/core/bpa_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/core/bitmap_page_allocator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// Page allocator: occupancy bitmap, owner slot table in RAM, four fit modes.
// ----------------------------------------------------------------------------
// Flow: a slot-table pass, then for a load a page scan, a pick state and an
//   update state; unload reads the slot back and then frees its pages. One
//   request at a time.
// Reset: a clearing pass writes every slot non-resident;
//   requests wait for it. Bitmap, pointer and fit_mode reset at once.
module bitmap_page_allocator #(
    parameter int NUM_PAGES = 64,
    parameter int NUM_SLOTS = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_wdata,
    input  wire logic       i_valid,
    output      logic       o_stall,
    input  wire logic       i_cmd,
    input  wire logic [7:0] i_owner_name,
    input  wire logic [6:0] i_page_count,
    output      logic       o_valid,
    input  wire logic       i_stall,
    output      logic [2:0] o_status,
    output      logic [5:0] o_start_page
);

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int PW = $clog2(NUM_PAGES);
    localparam int CW = PW + 1;
    // slot entry: resident, name, start, length
    localparam int EW = 1 + 8 + PW + CW;

    bpa_pkg::t_state r_state, n_state;
    bpa_pkg::t_fit   r_fit;
    logic [NUM_PAGES-1:0] r_map, n_map;
    logic [PW-1:0] r_nfp, n_nfp;
    logic [SW:0]   r_sidx, n_sidx;
    logic          r_found, n_found, r_hasfree, n_hasfree;
    logic [SW-1:0] r_fslot, n_fslot, r_eslot, n_eslot;
    logic          r_cmd;
    logic [7:0]    r_name;
    logic [6:0]    r_cnt;
    logic [CW-1:0] r_k;
    logic [PW:0]   r_pidx, n_pidx;
    logic [CW-1:0] r_run, n_run;
    logic [PW-1:0] r_rstart, n_rstart;
    logic          r_cand, n_cand, r_cand2, n_cand2;
    logic [PW-1:0] r_cpos, n_cpos, r_cpos2, n_cpos2;
    logic [CW-1:0] r_clen, n_clen;
    logic [2:0]    r_ostat, n_ostat;
    logic [5:0]    r_ostart, n_ostart;
    logic          r_ovalid, n_ovalid;

    logic          ram_we;
    logic [SW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    bpa_ram #(.WIDTH(EW), .DEPTH(NUM_SLOTS)) u_slots (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    logic          rd_res;
    logic [7:0]    rd_name;
    logic [PW-1:0] rd_start;
    logic [CW-1:0] rd_len;
    assign {rd_res, rd_name, rd_start, rd_len} = ram_rdata;

    assign o_stall      = (r_state != bpa_pkg::S_IDLE) || r_ovalid;
    assign o_valid      = r_ovalid;
    assign o_status     = r_ostat;
    assign o_start_page = r_ostart;

    logic accept;
    assign accept = i_valid && !o_stall;

    logic [PW-1:0] pidx_lo;
    logic          page_free;
    logic [CW-1:0] run_ext;
    logic [PW:0]   end_pos;
    assign pidx_lo   = r_pidx[PW-1:0];
    assign page_free = (r_pidx < (PW+1)'(NUM_PAGES)) && !r_map[pidx_lo];
    assign run_ext   = r_run + CW'(1);
    assign end_pos   = {1'b0, r_rstart} + (PW+1)'(r_k);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bpa_pkg::S_CLEAR;
            r_fit    <= bpa_pkg::FIT_FIRST;
            r_map    <= '0;
            r_nfp    <= '0;
            r_sidx   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_map    <= n_map;
            r_nfp    <= n_nfp;
            r_sidx   <= n_sidx;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_fit <= bpa_pkg::t_fit'(i_cfg_wdata);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_found   <= n_found;
        r_hasfree <= n_hasfree;
        r_fslot   <= n_fslot;
        r_eslot   <= n_eslot;
        r_pidx    <= n_pidx;
        r_run     <= n_run;
        r_rstart  <= n_rstart;
        r_cand    <= n_cand;
        r_cpos    <= n_cpos;
        r_cand2   <= n_cand2;
        r_cpos2   <= n_cpos2;
        r_clen    <= n_clen;
        r_ostat   <= n_ostat;
        r_ostart  <= n_ostart;
        if (accept) begin
            r_cmd  <= i_cmd;
            r_name <= i_owner_name;
            r_cnt  <= i_page_count;
            r_k    <= CW'(i_page_count);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_map     = r_map;
        n_nfp     = r_nfp;
        n_sidx    = r_sidx;
        n_found   = r_found;
        n_hasfree = r_hasfree;
        n_fslot   = r_fslot;
        n_eslot   = r_eslot;
        n_pidx    = r_pidx;
        n_run     = r_run;
        n_rstart  = r_rstart;
        n_cand    = r_cand;
        n_cpos    = r_cpos;
        n_cand2   = r_cand2;
        n_cpos2   = r_cpos2;
        n_clen    = r_clen;
        n_ostat   = r_ostat;
        n_ostart  = r_ostart;
        n_ovalid  = r_ovalid && i_stall;
        ram_we    = 1'b0;
        ram_waddr = r_sidx[SW-1:0];
        ram_wdata = '0;
        ram_raddr = r_sidx[SW-1:0];

        unique case (r_state)
            bpa_pkg::S_CLEAR: begin
                ram_we = 1'b1;
                n_sidx = r_sidx + (SW+1)'(1);
                if (r_sidx == (SW+1)'(NUM_SLOTS - 1)) begin
                    n_state = bpa_pkg::S_IDLE;
                end
            end
            bpa_pkg::S_IDLE: begin
                ram_raddr = '0;
                if (accept) begin
                    n_sidx    = (SW+1)'(1);
                    n_found   = 1'b0;
                    n_hasfree = 1'b0;
                    n_state   = (NUM_SLOTS > 1) ? bpa_pkg::S_SCAN : bpa_pkg::S_SCAN_LAST;
                end
            end
            bpa_pkg::S_SCAN, bpa_pkg::S_SCAN_LAST: begin
                // data for slot r_sidx-1 is on the RAM output
                if (rd_res && rd_name == r_name && !r_found) begin
                    n_found = 1'b1;
                    n_fslot = SW'(r_sidx - (SW+1)'(1));
                end
                if (!rd_res && !r_hasfree) begin
                    n_hasfree = 1'b1;
                    n_eslot   = SW'(r_sidx - (SW+1)'(1));
                end
                n_sidx = r_sidx + (SW+1)'(1);
                if (r_state == bpa_pkg::S_SCAN) begin
                    if (r_sidx == (SW+1)'(NUM_SLOTS - 1)) begin
                        n_state = bpa_pkg::S_SCAN_LAST;
                    end
                end else begin
                    n_pidx  = '0;
                    n_run   = '0;
                    n_cand  = 1'b0;
                    n_cand2 = 1'b0;
                    n_clen  = '0;
                    n_ostart = '0;
                    if (r_cmd == bpa_pkg::CMD_LOAD) begin
                        if (n_found) begin
                            n_ostat = bpa_pkg::ST_RESIDENT;
                            n_state = bpa_pkg::S_DONE;
                        end else if (!n_hasfree) begin
                            n_ostat = bpa_pkg::ST_FULL;
                            n_state = bpa_pkg::S_DONE;
                        end else if (r_cnt == 7'd0 || 32'(r_cnt) > NUM_PAGES) begin
                            n_ostat = bpa_pkg::ST_NO_RUN;
                            n_state = bpa_pkg::S_DONE;
                        end else begin
                            n_state = bpa_pkg::S_PAGES;
                        end
                    end else begin
                        if (n_found) begin
                            n_state = bpa_pkg::S_FREE_RD;
                        end else begin
                            n_ostat = bpa_pkg::ST_NOT_FOUND;
                            n_state = bpa_pkg::S_DONE;
                        end
                    end
                end
            end
            bpa_pkg::S_PAGES: begin
                // one page a cycle; one extra step closes the last hole
                if (page_free) begin
                    if (r_run == '0) begin
                        n_rstart = pidx_lo;
                    end
                    n_run = run_ext;
                    // first/next fit: a start position s is free for k once run reaches k
                    if (run_ext >= r_k) begin
                        if (!r_cand) begin
                            n_cand = 1'b1;
                            n_cpos = PW'(r_pidx - (PW+1)'(r_k) + (PW+1)'(1));
                        end
                        if (r_fit == bpa_pkg::FIT_NEXT && !r_cand2 &&
                            (r_pidx - (PW+1)'(r_k) + (PW+1)'(1)) >= (PW+1)'(r_nfp)) begin
                            n_cand2 = 1'b1;
                            n_cpos2 = PW'(r_pidx - (PW+1)'(r_k) + (PW+1)'(1));
                        end
                    end
                end else begin
                    n_run = '0;
                    if (r_run >= r_k && r_run != '0) begin
                        if (r_fit == bpa_pkg::FIT_BEST || r_fit == bpa_pkg::FIT_WORST) begin
                            if (r_clen == '0 ||
                                (r_fit == bpa_pkg::FIT_BEST  && r_run < r_clen) ||
                                (r_fit == bpa_pkg::FIT_WORST && r_run > r_clen)) begin
                                n_clen = r_run;
                                n_cpos2 = r_rstart;
                            end
                        end
                    end
                end
                n_pidx = r_pidx + (PW+1)'(1);
                if (r_pidx == (PW+1)'(NUM_PAGES)) begin
                    n_state = bpa_pkg::S_PAGE_FIN;
                end
            end
            bpa_pkg::S_PAGE_FIN: begin
                priority case (r_fit)
                    bpa_pkg::FIT_FIRST: begin
                        n_cand2 = r_cand;
                        n_cpos2 = r_cpos;
                    end
                    bpa_pkg::FIT_NEXT: begin
                        if (!r_cand2) begin
                            n_cand2 = r_cand;
                            n_cpos2 = r_cpos;
                        end
                    end
                    default: begin
                        n_cand2 = (r_clen != '0);
                    end
                endcase
                n_rstart = n_cpos2;
                if (n_cand2) begin
                    n_state = bpa_pkg::S_MARK;
                end else begin
                    n_ostat = bpa_pkg::ST_NO_RUN;
                    n_state = bpa_pkg::S_DONE;
                end
            end
            bpa_pkg::S_MARK: begin
                for (int p = 0; p < NUM_PAGES; p++) begin
                    if ((PW+1)'(p) >= {1'b0, r_rstart} && (PW+1)'(p) < end_pos) begin
                        n_map[p] = 1'b1;
                    end
                end
                ram_we    = 1'b1;
                ram_waddr = r_eslot;
                ram_wdata = {1'b1, r_name, r_rstart, r_k};
                n_nfp     = (end_pos >= (PW+1)'(NUM_PAGES)) ? '0 : end_pos[PW-1:0];
                n_ostat   = bpa_pkg::ST_OK;
                n_ostart  = 6'(r_rstart);
                n_state   = bpa_pkg::S_DONE;
            end
            bpa_pkg::S_FREE_RD: begin
                ram_raddr = r_fslot;
                n_state   = bpa_pkg::S_FREE;
            end
            bpa_pkg::S_FREE: begin
                for (int p = 0; p < NUM_PAGES; p++) begin
                    if ((PW+1)'(p) >= {1'b0, rd_start} &&
                        (PW+2)'(p) < ({2'b0, rd_start} + (PW+2)'(rd_len))) begin
                        n_map[p] = 1'b0;
                    end
                end
                ram_we    = 1'b1;
                ram_waddr = r_fslot;
                ram_wdata = {1'b0, rd_name, rd_start, rd_len};
                n_ostat   = bpa_pkg::ST_OK;
                n_state   = bpa_pkg::S_DONE;
            end
            bpa_pkg::S_DONE: begin
                n_ovalid = 1'b1;
                n_state  = bpa_pkg::S_IDLE;
            end
            default: begin
                n_state = bpa_pkg::S_IDLE;
            end
        endcase
    end

    // assertions
    a_ok_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != bpa_pkg::ST_OK |-> o_start_page == 6'd0)
        else $error("nonzero start on failure");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != bpa_pkg::S_IDLE |-> !accept)
        else $error("request taken while busy");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bpa_pkg::S_DONE |=> o_valid)
        else $error("result lost");

endmodule
`default_nettype wire
